[hw/rtl/sqe_pkg.sv]
// sprite quad expander shared types and constants
// request structs for the sprite and vertex channels, sequencer states
// no dependencies
package sqe_pkg;

    localparam int unsigned XFORM_REGS = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    // q16.16 one, and the half-lsb added before the final >>> 16
    localparam logic signed [31:0] ONE_Q16    = 32'sd65536;
    localparam logic signed [65:0] ROUND_HALF = 66'sd32768;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // identity matrix, two q16.16 elements per register
    localparam logic [CFG_DATA_W-1:0] XFORM_RESET [XFORM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] extent_x;
        logic signed [31:0] extent_y;
        logic [31:0]        tint_rgba;
        logic [31:0]        texture_id;
        logic [31:0]        uv_corner_a;
        logic [31:0]        uv_corner_b;
        logic [31:0]        uv_corner_c;
        logic [31:0]        uv_corner_d;
    } sprite_t;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic signed [31:0] vert_w;
        logic [31:0]        vert_color;
        logic [31:0]        vert_uv;
        logic               has_texture;
        logic [3:0]         tex_slot;
        logic               batch_flushed;
        logic               last_vertex;
    } vertex_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_CALC   = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

endpackage

[hw/rtl/sqe_intf.sv]
// valid/ready channel interfaces for sprites in and vertices out
// depends on sqe_pkg for the request structs
interface sqe_sprite_if;
    logic             valid;
    logic             ready;
    sqe_pkg::sprite_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sqe_vertex_if;
    logic             valid;
    logic             ready;
    sqe_pkg::vertex_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/sprite_quad_expander.sv]
// sprite quad expander top level: slot lookup, shared multiply-accumulate, vertex output
// depends on sqe_pkg and the channel interfaces in sqe_intf.sv
//
//  channel  | dir | modport | request
//  ---------+-----+---------+--------------------------------------------
//  sprite   | in  | sink    | one sprite: position, size, tint, uvs, texture id
//  vertex   | out | source  | one transformed vertex, four per sprite
//  cfg_*    | in  | -       | matrix register write, no handshake
//
//  one sprite: accept, then a slot table search when textured, then per vertex the matrix
//  products are issued, drained through the product and accumulator registers and output
//  all products go through the single shared 32x32 multiplier
//  sprite ready is high only in idle; a stalled vertex simply holds the sequencer
//  reset clears the sequencer and slot count and loads the identity matrix; slot table has no reset
module sprite_quad_expander #(
    parameter int unsigned TEXTURE_SLOTS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sqe_sprite_if.sink                       sprite,
    sqe_vertex_if.source                     vertex,
    input  logic                             cfg_we,
    input  logic [sqe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sqe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned SlotW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
    localparam int unsigned CntW  = $clog2(TEXTURE_SLOTS + 1);
    localparam logic [CntW-1:0] SlotsFull = CntW'(TEXTURE_SLOTS);

    // matrix registers
    logic [sqe_pkg::CFG_DATA_W-1:0] xform_reg [sqe_pkg::XFORM_REGS];

    // sequencer
    sqe_pkg::state_t state_reg, state_next;
    logic [1:0]      corner_reg, corner_next;
    logic [4:0]      issue_reg, issue_next;
    logic [CntW-1:0] search_reg, search_next;

    // slot table and its fill count
    logic [31:0]     slot_ids_reg [TEXTURE_SLOTS];
    logic [CntW-1:0] slots_used_reg, slots_used_next;
    logic            tab_we;
    logic [SlotW-1:0] tab_waddr;

    // captured sprite
    sqe_pkg::sprite_t spr_reg;
    logic signed [31:0] x1_reg, y1_reg;
    logic signed [31:0] x1_next, y1_next;
    logic [32:0]     sum_x, sum_y;

    // binding result
    logic            has_tex_reg, has_tex_next;
    logic [SlotW-1:0] slot_reg, slot_next;
    logic            flushed_reg, flushed_next;

    // multiply-accumulate pipeline
    logic signed [31:0] mat_a, vec_b;
    logic [31:0]        mat_word;
    logic [63:0]        mat_pair;
    logic [1:0]         iss_row, iss_col;
    logic               issuing;
    logic signed [63:0] prod_reg;
    logic               p1_valid_reg;
    logic [3:0]         p1_idx_reg;
    logic signed [65:0] acc_reg, acc_base;
    logic               fin_valid_reg;
    logic [1:0]         fin_row_reg;
    logic signed [31:0] sat_val;
    logic signed [31:0] pos_reg [4];

    logic sprite_fire, vertex_fire, id_hit;

    assign sprite.ready = (state_reg == sqe_pkg::ST_IDLE);
    assign sprite_fire  = sprite.valid && sprite.ready;
    assign vertex.valid = (state_reg == sqe_pkg::ST_OUT);
    assign vertex_fire  = vertex.valid && vertex.ready;

    // corner sums saturated to 32 bits
    assign sum_x = {sprite.data.origin_x[31], sprite.data.origin_x}
                 + {sprite.data.extent_x[31], sprite.data.extent_x};
    assign sum_y = {sprite.data.origin_y[31], sprite.data.origin_y}
                 + {sprite.data.extent_y[31], sprite.data.extent_y};

    always_comb
    begin
        if (sum_x[32] != sum_x[31])
        begin
            x1_next = sum_x[32] ? sqe_pkg::SAT_MIN : sqe_pkg::SAT_MAX;
        end
        else
        begin
            x1_next = sum_x[31:0];
        end
        if (sum_y[32] != sum_y[31])
        begin
            y1_next = sum_y[32] ? sqe_pkg::SAT_MIN : sqe_pkg::SAT_MAX;
        end
        else
        begin
            y1_next = sum_y[31:0];
        end
    end

    // lowest matching slot wins since the search walks upward
    assign id_hit = (slot_ids_reg[search_reg[SlotW-1:0]] == spr_reg.texture_id);

    // sequencer and slot binding
    always_comb
    begin
        state_next      = state_reg;
        corner_next     = corner_reg;
        issue_next      = issue_reg;
        search_next     = search_reg;
        slots_used_next = slots_used_reg;
        has_tex_next    = has_tex_reg;
        slot_next       = slot_reg;
        flushed_next    = flushed_reg;
        tab_we          = 1'b0;
        tab_waddr       = slots_used_reg[SlotW-1:0];

        unique case (state_reg)
            sqe_pkg::ST_IDLE:
            begin
                if (sprite_fire)
                begin
                    corner_next  = 2'd0;
                    issue_next   = 5'd0;
                    search_next  = '0;
                    slot_next    = '0;
                    flushed_next = 1'b0;
                    has_tex_next = (sprite.data.texture_id != 32'd0);
                    state_next   = (sprite.data.texture_id != 32'd0) ? sqe_pkg::ST_SEARCH
                                                                     : sqe_pkg::ST_CALC;
                end
            end
            sqe_pkg::ST_SEARCH:
            begin
                if (search_reg == slots_used_reg)
                begin
                    // id not present: take the next slot, flushing a full table
                    tab_we = 1'b1;
                    if (slots_used_reg == SlotsFull)
                    begin
                        tab_waddr       = '0;
                        slot_next       = '0;
                        flushed_next    = 1'b1;
                        slots_used_next = CntW'(1);
                    end
                    else
                    begin
                        slot_next       = slots_used_reg[SlotW-1:0];
                        slots_used_next = slots_used_reg + CntW'(1);
                    end
                    state_next = sqe_pkg::ST_CALC;
                end
                else if (id_hit)
                begin
                    slot_next  = search_reg[SlotW-1:0];
                    state_next = sqe_pkg::ST_CALC;
                end
                else
                begin
                    search_next = search_reg + CntW'(1);
                end
            end
            sqe_pkg::ST_CALC:
            begin
                if (issuing)
                begin
                    issue_next = issue_reg + 5'd1;
                end
                if (fin_valid_reg && (fin_row_reg == 2'd3))
                begin
                    state_next = sqe_pkg::ST_OUT;
                end
            end
            sqe_pkg::ST_OUT:
            begin
                if (vertex_fire)
                begin
                    if (corner_reg == 2'd3)
                    begin
                        state_next = sqe_pkg::ST_IDLE;
                    end
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                        issue_next  = 5'd0;
                        state_next  = sqe_pkg::ST_CALC;
                    end
                end
            end
            default:
            begin
                state_next = sqe_pkg::ST_IDLE;
            end
        endcase
    end

    // operand select for the shared multiplier: row r, column c of vertex k
    assign issuing = (state_reg == sqe_pkg::ST_CALC) && !issue_reg[4];
    assign iss_row = issue_reg[3:2];
    assign iss_col = issue_reg[1:0];
    assign mat_pair = xform_reg[{iss_row, iss_col[1]}];
    assign mat_word = iss_col[0] ? mat_pair[63:32] : mat_pair[31:0];
    assign mat_a    = mat_word;

    always_comb
    begin
        unique case (iss_col)
            2'd0:    vec_b = corner_reg[1] ? x1_reg : spr_reg.origin_x;
            2'd1:    vec_b = corner_reg[0] ? y1_reg : spr_reg.origin_y;
            2'd2:    vec_b = spr_reg.origin_z;
            default: vec_b = sqe_pkg::ONE_Q16;
        endcase
    end

    // accumulator starts each row at the rounding half
    assign acc_base = (p1_idx_reg[1:0] == 2'd0) ? sqe_pkg::ROUND_HALF : acc_reg;

    // saturate (acc >>> 16) to 32 bits: in range when bits 65..47 agree
    always_comb
    begin
        if ((acc_reg[65:47] == '0) || (acc_reg[65:47] == '1))
        begin
            sat_val = acc_reg[47:16];
        end
        else
        begin
            sat_val = acc_reg[65] ? sqe_pkg::SAT_MIN : sqe_pkg::SAT_MAX;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sqe_pkg::ST_IDLE;
            corner_reg     <= 2'd0;
            issue_reg      <= 5'd0;
            search_reg     <= '0;
            slots_used_reg <= '0;
            p1_valid_reg   <= 1'b0;
            fin_valid_reg  <= 1'b0;
            for (int i = 0; i < int'(sqe_pkg::XFORM_REGS); i++)
            begin
                xform_reg[i] <= sqe_pkg::XFORM_RESET[i];
            end
        end
        else
        begin
            state_reg      <= state_next;
            corner_reg     <= corner_next;
            issue_reg      <= issue_next;
            search_reg     <= search_next;
            slots_used_reg <= slots_used_next;
            p1_valid_reg   <= issuing;
            fin_valid_reg  <= p1_valid_reg && (p1_idx_reg[1:0] == 2'd3);
            if (cfg_we)
            begin
                xform_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sprite_fire)
        begin
            spr_reg <= sprite.data;
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
        end
        has_tex_reg <= has_tex_next;
        slot_reg    <= slot_next;
        flushed_reg <= flushed_next;
        if (tab_we)
        begin
            slot_ids_reg[tab_waddr] <= spr_reg.texture_id;
        end
        prod_reg   <= mat_a * vec_b;
        p1_idx_reg <= issue_reg[3:0];
        if (p1_valid_reg)
        begin
            acc_reg     <= acc_base + {{2{prod_reg[63]}}, prod_reg};
            fin_row_reg <= p1_idx_reg[3:2];
        end
        if (fin_valid_reg)
        begin
            pos_reg[fin_row_reg] <= sat_val;
        end
    end

    // vertex request
    always_comb
    begin
        vertex.data.vert_x        = pos_reg[0];
        vertex.data.vert_y        = pos_reg[1];
        vertex.data.vert_z        = pos_reg[2];
        vertex.data.vert_w        = pos_reg[3];
        vertex.data.vert_color    = spr_reg.tint_rgba;
        vertex.data.has_texture   = has_tex_reg;
        vertex.data.tex_slot      = 4'(slot_reg);
        vertex.data.batch_flushed = flushed_reg && (corner_reg == 2'd0);
        vertex.data.last_vertex   = (corner_reg == 2'd3);
        unique case (corner_reg)
            2'd0:    vertex.data.vert_uv = spr_reg.uv_corner_a;
            2'd1:    vertex.data.vert_uv = spr_reg.uv_corner_b;
            2'd2:    vertex.data.vert_uv = spr_reg.uv_corner_c;
            default: vertex.data.vert_uv = spr_reg.uv_corner_d;
        endcase
    end

endmodule

[dv/tb_sprite_quad_expander.sv]
`timescale 1ns / 1ps
// testbench for sprite_quad_expander: sprites in, four transformed vertices out per sprite
// depends on sqe_pkg, the channel interfaces in sqe_intf.sv and the rtl top level
module tb_sprite_quad_expander;

    localparam int unsigned SLOTS         = 16;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    // settle time after the last predicted vertex, so the block is back in idle
    localparam int unsigned SETTLE_CYCLES = 8;
    // extra watch time at the end after the last sprite has drained
    localparam int unsigned TAIL_CYCLES   = 150;
    localparam int unsigned SWEEP_BATCH   = 39;

    // matrix register map, two q16.16 elements per register
    typedef enum logic [sqe_pkg::CFG_IDX_W-1:0] {
        XF_ROW0_LEFT,
        XF_ROW0_RIGHT,
        XF_ROW1_LEFT,
        XF_ROW1_RIGHT,
        XF_ROW2_LEFT,
        XF_ROW2_RIGHT,
        XF_ROW3_LEFT,
        XF_ROW3_RIGHT
    } xform_reg_e;

    // matrix settings visited by the sweep
    typedef enum int {
        MX_ALL_MAX,
        MX_ALL_MIN,
        MX_ALL_ZERO,
        MX_ALL_NEG_LSB,
        MX_SCALE_SHIFT,
        MX_RANDOM
    } xform_mode_e;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sqe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sqe_pkg::CFG_DATA_W-1:0] cfg_data;

    sqe_sprite_if sprite_ch ();
    sqe_vertex_if vertex_ch ();

    sprite_quad_expander #(
        .TEXTURE_SLOTS (SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sprite    (sprite_ch),
        .vertex    (vertex_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block: matrix registers, texture slot table, slot count
    logic [sqe_pkg::CFG_DATA_W-1:0] xform_shadow [sqe_pkg::XFORM_REGS];
    logic [31:0]           slot_ids [SLOTS];
    int unsigned           slot_count;

    // vertices predicted from accepted sprites, oldest first
    sqe_pkg::vertex_t      pending_vertices [$];

    int unsigned           mismatches = 0;
    longint unsigned       cycle_count = 0;

    // when set, that side runs without idle cycles
    bit                    sender_quiet = 1'b0;
    bit                    sink_quiet   = 1'b0;

    // texture ids reused by random sprites; more ids than slots forces table flushes
    logic [31:0]           tex_pool [20];

    // ------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // vertex prediction
    // ------------------------------------------------------------------

    // element c of matrix row r, low half holds the even column
    function automatic logic signed [31:0] xform_elem(input int r, input int c);
        logic [sqe_pkg::CFG_DATA_W-1:0] word;
        word = xform_shadow[r * 2 + c / 2];
        return (c % 2 != 0) ? word[63:32] : word[31:0];
    endfunction

    // corner coordinate x+w or y+h, clamped to signed 32 bits
    function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? sqe_pkg::SAT_MIN : sqe_pkg::SAT_MAX;
        return s[31:0];
    endfunction

    // one output coordinate: exact q32.32 dot product, round half up, saturate
    function automatic logic signed [31:0] row_transform(input int r,
                                                         input logic signed [31:0] vx,
                                                         input logic signed [31:0] vy,
                                                         input logic signed [31:0] vz);
        logic signed [31:0] vec [4];
        logic signed [67:0] acc;
        int                 c;
        vec[0] = vx;
        vec[1] = vy;
        vec[2] = vz;
        vec[3] = sqe_pkg::ONE_Q16;
        acc = '0;
        for (c = 0; c < 4; c++)
            acc = acc + xform_elem(r, c) * vec[c];
        acc = (acc + sqe_pkg::ROUND_HALF) >>> 16;
        if (acc > sqe_pkg::SAT_MAX)
            return sqe_pkg::SAT_MAX;
        if (acc < sqe_pkg::SAT_MIN)
            return sqe_pkg::SAT_MIN;
        return acc[31:0];
    endfunction

    // bind the texture slot, then queue vertices a, b, c, d of the accepted sprite
    function automatic void expand_sprite(input sqe_pkg::sprite_t s);
        logic signed [31:0] far_x;
        logic signed [31:0] far_y;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               textured;
        logic               flushed;
        logic               hit;
        int unsigned        slot_num;
        int unsigned        i;
        int                 k;
        sqe_pkg::vertex_t   v;

        far_x    = sat_sum(s.origin_x, s.extent_x);
        far_y    = sat_sum(s.origin_y, s.extent_y);
        textured = 1'b0;
        flushed  = 1'b0;
        hit      = 1'b0;
        slot_num = 0;

        // texture id 0 leaves the table alone and reports slot 0
        if (s.texture_id != '0)
        begin
            textured = 1'b1;
            // lowest matching slot wins
            for (i = 0; i < slot_count; i++)
            begin
                if (!hit && slot_ids[i] == s.texture_id)
                begin
                    hit      = 1'b1;
                    slot_num = i;
                end
            end
            if (!hit)
            begin
                // full table: start a new batch from slot 0
                if (slot_count >= SLOTS)
                begin
                    slot_count = 0;
                    flushed    = 1'b1;
                end
                slot_num             = slot_count;
                slot_ids[slot_count] = s.texture_id;
                slot_count++;
            end
        end

        for (k = 0; k < 4; k++)
        begin
            cx = (k & 2) ? far_x : s.origin_x;
            cy = (k & 1) ? far_y : s.origin_y;
            v.vert_x        = row_transform(0, cx, cy, s.origin_z);
            v.vert_y        = row_transform(1, cx, cy, s.origin_z);
            v.vert_z        = row_transform(2, cx, cy, s.origin_z);
            v.vert_w        = row_transform(3, cx, cy, s.origin_z);
            v.vert_color    = s.tint_rgba;
            case (k)
                0:       v.vert_uv = s.uv_corner_a;
                1:       v.vert_uv = s.uv_corner_b;
                2:       v.vert_uv = s.uv_corner_c;
                default: v.vert_uv = s.uv_corner_d;
            endcase
            v.has_texture   = textured;
            v.tex_slot      = 4'(slot_num);
            v.batch_flushed = (k == 0) ? flushed : 1'b0;
            v.last_vertex   = (k == 3);
            pending_vertices = {pending_vertices, v};
        end
    endfunction

    // ------------------------------------------------------------------
    // vertex checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("vertex mismatch on %s: expected %h, got %h", field, want, got);
        end
    endfunction

    // every vertex request taken by the testbench is compared with the oldest prediction
    always @(posedge clk)
    begin
        sqe_pkg::vertex_t want;
        sqe_pkg::vertex_t got;
        if (rst_n && vertex_ch.valid && vertex_ch.ready)
        begin
            got = vertex_ch.data;
            if (pending_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("vertex with no sprite pending: %h", got);
            end
            else
            begin
                want = pending_vertices.pop_front();
                check_field("vert_x", want.vert_x, got.vert_x);
                check_field("vert_y", want.vert_y, got.vert_y);
                check_field("vert_z", want.vert_z, got.vert_z);
                check_field("vert_w", want.vert_w, got.vert_w);
                check_field("vert_color", want.vert_color, got.vert_color);
                check_field("vert_uv", want.vert_uv, got.vert_uv);
                check_field("has_texture", 32'(want.has_texture), 32'(got.has_texture));
                check_field("tex_slot", 32'(want.tex_slot), 32'(got.tex_slot));
                check_field("batch_flushed", 32'(want.batch_flushed),
                            32'(got.batch_flushed));
                check_field("last_vertex", 32'(want.last_vertex), 32'(got.last_vertex));
            end
        end
    end

    // ------------------------------------------------------------------
    // idle draws and random values
    // ------------------------------------------------------------------

    // cycles a side waits before its next request, zero in quiet stretches
    function automatic int unsigned draw_wait(input bit quiet);
        if (quiet || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 4))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return 32'h0001_0000;
        endcase
    endfunction

    // sprite coordinate: full range, within +-256.0, or an extreme
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1, 2:    return $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
            default: return extreme_word();
        endcase
    endfunction

    // matrix element: full range, within +-4.0, or an extreme
    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1, 2:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return extreme_word();
        endcase
    endfunction

    // texture id: mostly from the reuse pool, some untextured, some fresh
    function automatic logic [31:0] rand_texture();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            return '0;
        if (pick < 16)
            return tex_pool[$urandom_range(0, 19)];
        return $urandom;
    endfunction

    function automatic sqe_pkg::sprite_t rand_sprite();
        sqe_pkg::sprite_t s;
        s.origin_x    = rand_coord();
        s.origin_y    = rand_coord();
        s.origin_z    = rand_coord();
        s.extent_x    = rand_coord();
        s.extent_y    = rand_coord();
        s.tint_rgba   = $urandom;
        s.texture_id  = rand_texture();
        s.uv_corner_a = $urandom;
        s.uv_corner_b = $urandom;
        s.uv_corner_c = $urandom;
        s.uv_corner_d = $urandom;
        return s;
    endfunction

    // directed sprite; the four uv words are spread out from one seed word
    function automatic sqe_pkg::sprite_t corner_sprite(input logic [31:0] ox,
                                                       input logic [31:0] oy,
                                                       input logic [31:0] oz,
                                                       input logic [31:0] ex,
                                                       input logic [31:0] ey,
                                                       input logic [31:0] tint,
                                                       input logic [31:0] tid,
                                                       input logic [31:0] uv);
        sqe_pkg::sprite_t s;
        s.origin_x    = ox;
        s.origin_y    = oy;
        s.origin_z    = oz;
        s.extent_x    = ex;
        s.extent_y    = ey;
        s.tint_rgba   = tint;
        s.texture_id  = tid;
        s.uv_corner_a = uv;
        s.uv_corner_b = ~uv;
        s.uv_corner_c = {uv[15:0], uv[31:16]};
        s.uv_corner_d = uv ^ 32'h5a5a_a5a5;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // channel and register drivers
    // ------------------------------------------------------------------

    // offer one sprite request and predict its vertices once it is taken;
    // valid stays high after acceptance so a back-to-back request never toggles it
    task automatic send_sprite(input sqe_pkg::sprite_t s);
        int unsigned gap;
        gap = draw_wait(sender_quiet);
        if (gap != 0)
        begin
            sprite_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sprite_ch.valid <= 1'b1;
        sprite_ch.data  <= s;
        @(posedge clk);
        while (!sprite_ch.ready)
            @(posedge clk);
        expand_sprite(s);
    endtask

    // hold off new sprites until every predicted vertex has come back
    task automatic drain_vertices();
        sprite_ch.valid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all eight matrix registers on consecutive cycles, block must be idle
    task automatic load_xform(input logic [sqe_pkg::CFG_DATA_W-1:0] m [sqe_pkg::XFORM_REGS]);
        xform_reg_e idx;
        idx = idx.first();
        do
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= m[idx];
            xform_shadow[idx] = m[idx];
            @(posedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_we <= 1'b0;
    endtask

    task automatic make_xform(input xform_mode_e mode,
                              output logic [sqe_pkg::CFG_DATA_W-1:0] m [sqe_pkg::XFORM_REGS]);
        int i;
        for (i = 0; i < sqe_pkg::XFORM_REGS; i++)
        begin
            case (mode)
                MX_ALL_MAX:     m[i] = {2{32'h7fff_ffff}};
                MX_ALL_MIN:     m[i] = {2{32'h8000_0000}};
                MX_ALL_ZERO:    m[i] = '0;
                MX_ALL_NEG_LSB: m[i] = {2{32'hffff_ffff}};
                default:        m[i] = {rand_elem(), rand_elem()};
            endcase
        end
        // scale x by 2.0, y by -1.5, z by 0.25, with a translation and a small w term
        if (mode == MX_SCALE_SHIFT)
        begin
            m[XF_ROW0_LEFT]  = {32'h0000_0000, 32'h0002_0000};
            m[XF_ROW0_RIGHT] = {32'h0040_0000, 32'h0000_0000};
            m[XF_ROW1_LEFT]  = {32'hfffe_8000, 32'h0000_0000};
            m[XF_ROW1_RIGHT] = {32'hffe0_0000, 32'h0000_0000};
            m[XF_ROW2_LEFT]  = {32'h0000_0000, 32'h0000_0000};
            m[XF_ROW2_RIGHT] = {32'h0000_0000, 32'h0000_4000};
            m[XF_ROW3_LEFT]  = {32'h0000_0000, 32'h0000_0100};
            m[XF_ROW3_RIGHT] = {32'h0001_0000, 32'h0000_0000};
        end
    endtask

    // ------------------------------------------------------------------
    // vertex sink: ready drops for a random number of cycles before each vertex
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        vertex_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = draw_wait(sink_quiet);
            if (stall != 0)
            begin
                vertex_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            vertex_ch.ready <= 1'b1;
            @(posedge clk);
            while (!vertex_ch.valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // identity matrix from reset: zeros, saturating corners, textured and untextured
    task automatic test_directed_corners();
        // all zero, untextured
        send_sprite(corner_sprite('0, '0, '0, '0, '0, '0, '0, '0));
        // largest position and size, corner sums clamp high
        send_sprite(corner_sprite(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        // most negative position and size, corner sums clamp low
        send_sprite(corner_sprite(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, '0, 32'h0000_0001, '0));
        // ordinary sprite, texture id seen before so it hits its old slot
        send_sprite(corner_sprite(32'h000a_0000, 32'h0014_0000, 32'h0000_8000, 32'h0020_0000,
                                  32'h0010_0000, 32'h8040_2010, 32'hffff_ffff, 32'h4000_4000));
        // negative extents, fractional origin, untextured
        send_sprite(corner_sprite(32'hfffa_8000, 32'h0003_4000, 32'hffff_0000, 32'hfff0_0000,
                                  32'hffe0_0001, 32'h55aa_55aa, '0, 32'haaaa_aaaa));
        // mixed extremes: x clamps high, y clamps low
        send_sprite(corner_sprite(32'h7fff_0000, 32'h8000_ffff, 32'h0000_0001, 32'h0100_0000,
                                  32'hff00_0000, 32'h0000_00ff, 32'h8000_0000, 32'h0000_ffff));
    endtask

    // fill every slot, then one more id flushes the table and starts over at slot 0
    task automatic test_slot_table_wrap();
        logic [31:0]      next_id;
        sqe_pkg::sprite_t s;
        next_id = 32'h0000_0100;
        while (slot_count < SLOTS)
        begin
            s = rand_sprite();
            s.texture_id = next_id;
            send_sprite(s);
            next_id++;
        end
        s = rand_sprite();
        s.texture_id = 32'h1234_5678;
        send_sprite(s);
        // id from before the flush must take a fresh slot
        s = rand_sprite();
        s.texture_id = 32'hffff_ffff;
        send_sprite(s);
        // id that caused the flush hits slot 0
        s = rand_sprite();
        s.texture_id = 32'h1234_5678;
        send_sprite(s);
    endtask

    // random sprites under a series of matrix settings, extremes first
    task automatic test_xform_sweep();
        logic [sqe_pkg::CFG_DATA_W-1:0] m [sqe_pkg::XFORM_REGS];
        xform_mode_e           modes [9];
        int                    p;
        int                    n;
        modes = '{MX_ALL_MAX, MX_ALL_MIN, MX_ALL_ZERO, MX_ALL_NEG_LSB, MX_SCALE_SHIFT,
                  MX_RANDOM, MX_RANDOM, MX_RANDOM, MX_RANDOM};
        for (p = 0; p < 9; p++)
        begin
            drain_vertices();
            make_xform(modes[p], m);
            load_xform(m);
            sender_quiet = ($urandom_range(0, 3) == 0);
            sink_quiet   = ($urandom_range(0, 3) == 0);
            for (n = 0; n < SWEEP_BATCH; n++)
                send_sprite(rand_sprite());
        end
        sender_quiet = 1'b0;
        sink_quiet   = 1'b0;
    endtask

    // the sender stops mid stream until the block has emptied, then resumes
    task automatic test_pause_until_drained();
        int n;
        for (n = 0; n < 20; n++)
            send_sprite(rand_sprite());
        drain_vertices();
        for (n = 0; n < 20; n++)
            send_sprite(rand_sprite());
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        rst_n           <= 1'b0;
        sprite_ch.valid <= 1'b0;
        sprite_ch.data  <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= XF_ROW0_LEFT;
        cfg_data        <= '0;

        xform_shadow = sqe_pkg::XFORM_RESET;
        slot_count   = 0;
        for (i = 0; i < SLOTS; i++)
            slot_ids[i] = '0;
        for (i = 0; i < 20; i++)
            tex_pool[i] = $urandom_range(1, 32'hffff_ffff);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_slot_table_wrap();
        test_xform_sweep();
        test_pause_until_drained();

        drain_vertices();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/sqe_pkg.sv
hw/rtl/sqe_intf.sv
hw/rtl/sprite_quad_expander.sv
dv/tb_sprite_quad_expander.sv
